>>> sv/i2cms_pkg.sv
package i2cms_pkg;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP  = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ  = 3'd3,
		OP_ACK   = 3'd4,
		OP_NACK  = 3'd5,
		OP_RACK  = 3'd6
	} opcode_t;

	localparam logic [2:0] OPCODE_MAX    = 3'd6;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic scl;
		logic sda;
		logic drv;
	} lines_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [15:0] tick;
		logic [3:0]  bit_idx;
		logic [7:0]  shift;
		opcode_t     cmd;
		lines_t      lines;
		logic        ack;
		logic [7:0]  rd;
	} seq_state_t;

endpackage

>>> sv/i2cms_step.sv
module i2cms_step (
	input  i2cms_pkg::seq_state_t st,
	input  logic                  cmd_valid,
	input  logic [2:0]            opcode,
	input  logic [7:0]            write_data,
	input  logic                  sda_pin,
	input  logic [15:0]           phase_ticks,
	output i2cms_pkg::seq_state_t nxt,
	output logic                  done
);

	function automatic i2cms_pkg::lines_t apply_phase(i2cms_pkg::opcode_t c, logic [2:0] p,
			logic [7:0] sh, logic sda_old);
		i2cms_pkg::lines_t l;
		logic v;
		v = (c == i2cms_pkg::OP_NACK);
		unique case (c)
			i2cms_pkg::OP_START: l = '{scl: 1'b1, sda: (p == 3'd1), drv: 1'b1};
			i2cms_pkg::OP_STOP:  l = '{scl: 1'b1, sda: (p != 3'd1), drv: 1'b1};
			i2cms_pkg::OP_WRITE: l = '{scl: (p != 3'd1), sda: sh[7], drv: 1'b1};
			i2cms_pkg::OP_READ:  l = '{scl: (p != 3'd1), sda: 1'b1, drv: 1'b0};
			i2cms_pkg::OP_ACK, i2cms_pkg::OP_NACK: begin
				if (p == 3'd1) l = '{scl: 1'b0, sda: sda_old, drv: 1'b1};
				else if (p == 3'd2) l = '{scl: 1'b0, sda: v, drv: 1'b1};
				else l = '{scl: 1'b1, sda: v, drv: 1'b1};
			end
			default: begin
				if (p == 3'd1) l = '{scl: 1'b0, sda: sda_old, drv: 1'b1};
				else if (p == 3'd2) l = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
				else l = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
			end
		endcase
		return l;
	endfunction

	logic [15:0] hold;
	logic [15:0] tick_inc;
	logic [3:0]  bit_inc;
	logic [7:0]  shift_new;
	logic [2:0]  last_phase;
	logic        is_byte;

	assign hold      = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
	assign tick_inc  = st.tick + 16'd1;
	assign bit_inc   = st.bit_idx + 4'd1;
	assign is_byte   = (st.cmd == i2cms_pkg::OP_WRITE) || (st.cmd == i2cms_pkg::OP_READ);
	assign shift_new = {st.shift[6:0], (st.cmd == i2cms_pkg::OP_READ) ? sda_pin : 1'b0};
	assign last_phase = ((st.cmd == i2cms_pkg::OP_ACK) || (st.cmd == i2cms_pkg::OP_NACK)) ? 3'd4 :
		(st.cmd == i2cms_pkg::OP_RACK) ? 3'd3 : 3'd2;

	always_comb begin
		nxt  = st;
		done = 1'b0;
		if (st.phase == 3'd0) begin
			if (cmd_valid && (opcode <= i2cms_pkg::OPCODE_MAX)) begin
				nxt.cmd     = i2cms_pkg::opcode_t'(opcode);
				nxt.phase   = 3'd1;
				nxt.tick    = 16'd0;
				nxt.bit_idx = 4'd0;
				nxt.shift   = (opcode == i2cms_pkg::OP_WRITE) ? write_data : 8'd0;
				nxt.lines   = apply_phase(nxt.cmd, 3'd1, nxt.shift, st.lines.sda);
			end
		end else begin
			nxt.tick = tick_inc;
			if (tick_inc >= hold) begin
				nxt.tick = 16'd0;
				if (is_byte) begin
					if (st.phase == 3'd2) begin
						nxt.shift   = shift_new;
						nxt.bit_idx = bit_inc;
						if (bit_inc >= i2cms_pkg::BITS_PER_BYTE) begin
							done          = 1'b1;
							nxt.phase     = 3'd0;
							nxt.lines.scl = 1'b0;
							nxt.lines.drv = 1'b1;
							if (st.cmd == i2cms_pkg::OP_READ) nxt.rd = shift_new;
						end else begin
							nxt.phase = 3'd1;
							nxt.lines = apply_phase(st.cmd, 3'd1, shift_new, st.lines.sda);
						end
					end else begin
						nxt.phase = 3'd2;
						nxt.lines = apply_phase(st.cmd, 3'd2, st.shift, st.lines.sda);
					end
				end else if (st.phase >= last_phase) begin
					done      = 1'b1;
					nxt.phase = 3'd0;
					if (st.cmd == i2cms_pkg::OP_RACK) nxt.ack = sda_pin;
					if ((st.cmd != i2cms_pkg::OP_START) && (st.cmd != i2cms_pkg::OP_STOP)) begin
						nxt.lines.scl = 1'b0;
						nxt.lines.drv = 1'b1;
					end
				end else begin
					nxt.phase = st.phase + 3'd1;
					nxt.lines = apply_phase(st.cmd, nxt.phase, st.shift, st.lines.sda);
				end
			end
		end
	end

endmodule

>>> sv/i2cms_top_placeholder.sv
module i2cms_out_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic       out_ready,
	input  logic [13:0] din,
	output logic       out_valid,
	output logic [13:0] dout
);

	logic        valid_q;
	logic [13:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign out_valid = valid_q;
	assign dout      = data_q;

endmodule

>>> sv/i2c_master_bit_sequencer.sv
// An input register and a result register part the two sides, step logic between.
// One word per cycle, unless a held result (out_ready low) stalls the pipeline.
// Each word advances the bus sequencer by one tick in a single registered pass.
// Reset (arst_n low, asynchronous): sequencer idle, its SCL/SDA high and driven,
// phase_ticks 1, its read byte and ack 0, no words held; result data is not reset.
module i2c_master_bit_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd_valid,
	input  logic [2:0]  opcode,
	input  logic [7:0]  write_data,
	input  logic        sda_pin,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_level,
	output logic        sda_level,
	output logic        sda_drive,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        ack_bit
);

	logic [15:0] phase_ticks_q;
	logic        valid_s1;
	logic        cmd_valid_s1;
	logic [2:0]  opcode_s1;
	logic [7:0]  write_data_s1;
	logic        sda_pin_s1;
	logic        advance;
	logic        done;
	logic [13:0] res_d;
	logic [13:0] res_q;

	i2cms_pkg::seq_state_t state_q;
	i2cms_pkg::seq_state_t state_d;

	assign advance  = valid_s1 & (~out_valid | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= 16'd1;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_valid_s1  <= cmd_valid;
			opcode_s1     <= opcode;
			write_data_s1 <= write_data;
			sda_pin_s1    <= sda_pin;
		end
	end

	i2cms_step u_step (
		.st          (state_q),
		.cmd_valid   (cmd_valid_s1),
		.opcode      (opcode_s1),
		.write_data  (write_data_s1),
		.sda_pin     (sda_pin_s1),
		.phase_ticks (phase_ticks_q),
		.nxt         (state_d),
		.done        (done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= 3'd0;
			state_q.tick    <= 16'd0;
			state_q.bit_idx <= 4'd0;
			state_q.shift   <= 8'd0;
			state_q.cmd     <= i2cms_pkg::OP_START;
			state_q.lines   <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
			state_q.ack     <= 1'b0;
			state_q.rd      <= 8'd0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	assign res_d = {state_d.lines.scl, state_d.lines.sda, state_d.lines.drv,
		(state_d.phase != 3'd0), done, state_d.rd, state_d.ack};

	i2cms_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.out_ready (out_ready),
		.din       (res_d),
		.out_valid (out_valid),
		.dout      (res_q)
	);

	assign scl_level = res_q[13];
	assign sda_level = res_q[12];
	assign sda_drive = res_q[11];
	assign busy_res  = res_q[10];
	assign done_res  = res_q[9];
	assign read_data = res_q[8:1];
	assign ack_bit   = res_q[0];

endmodule

>>> bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drv;
		logic       busy;
		logic       done;
		logic [7:0] rd;
		logic       ack;
	} bus_tick_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        cmd_valid;
	logic [2:0]  opcode;
	logic [7:0]  write_data;
	logic        sda_pin;
	logic        out_valid;
	logic        out_ready;
	logic        scl_level;
	logic        sda_level;
	logic        sda_drive;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_data;
	logic        ack_bit;

	bus_tick_t   expected_ticks[$];
	int          errors = 0;
	int unsigned ticks_sent = 0;
	int unsigned cycle_count = 0;
	int          send_gap_pct = 15;
	int          recv_gap_pct = 15;
	int          hold_request = 0;
	int          recv_wait = 0;

	logic [15:0]         cfg_phase_ticks;
	logic [3:0]          seq_phase;
	logic [15:0]         seq_count;
	logic [3:0]          seq_bit;
	logic [7:0]          seq_shift;
	i2cms_pkg::opcode_t  seq_cmd;
	logic                seq_scl;
	logic                seq_sda;
	logic                seq_drv;
	logic                seq_ack;
	logic [7:0]          seq_rd;

	i2c_master_bit_sequencer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd_valid  (cmd_valid),
		.opcode     (opcode),
		.write_data (write_data),
		.sda_pin    (sda_pin),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.scl_level  (scl_level),
		.sda_level  (sda_level),
		.sda_drive  (sda_drive),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_data  (read_data),
		.ack_bit    (ack_bit)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 20);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic line_sample(input int mode);
		if (mode == 2)
			return 1'($urandom_range(1));
		return mode[0];
	endfunction

	function automatic logic [3:0] phase_total(input i2cms_pkg::opcode_t cmd);
		if (cmd == i2cms_pkg::OP_ACK || cmd == i2cms_pkg::OP_NACK)
			return 4'd4;
		if (cmd == i2cms_pkg::OP_RACK)
			return 4'd3;
		return 4'd2;
	endfunction

	function automatic void drive_phase_lines();
		logic lvl;
		lvl = (seq_cmd == i2cms_pkg::OP_NACK);
		case (seq_cmd)
			i2cms_pkg::OP_START: begin
				seq_scl = 1'b1; seq_sda = (seq_phase == 4'd1); seq_drv = 1'b1;
			end
			i2cms_pkg::OP_STOP: begin
				seq_scl = 1'b1; seq_sda = (seq_phase != 4'd1); seq_drv = 1'b1;
			end
			i2cms_pkg::OP_WRITE: begin
				seq_scl = (seq_phase != 4'd1); seq_sda = seq_shift[7]; seq_drv = 1'b1;
			end
			i2cms_pkg::OP_READ: begin
				seq_scl = (seq_phase != 4'd1); seq_sda = 1'b1; seq_drv = 1'b0;
			end
			i2cms_pkg::OP_ACK, i2cms_pkg::OP_NACK: begin
				seq_drv = 1'b1;
				if (seq_phase == 4'd1) begin
					seq_scl = 1'b0;
				end else begin
					seq_scl = (seq_phase != 4'd2);
					seq_sda = lvl;
				end
			end
			default: begin
				if (seq_phase == 4'd1) begin
					seq_scl = 1'b0; seq_drv = 1'b1;
				end else begin
					seq_scl = (seq_phase != 4'd2); seq_sda = 1'b1; seq_drv = 1'b0;
				end
			end
		endcase
	endfunction

	function automatic void end_command();
		seq_phase = 4'd0;
		seq_count = 16'd0;
		if (seq_cmd != i2cms_pkg::OP_START && seq_cmd != i2cms_pkg::OP_STOP) begin
			seq_scl = 1'b0;
			seq_drv = 1'b1;
			if (seq_cmd == i2cms_pkg::OP_READ)
				seq_rd = seq_shift;
		end
	endfunction

	function automatic logic next_phase(input logic pin);
		logic fin;
		fin = 1'b0;
		if (seq_cmd == i2cms_pkg::OP_WRITE || seq_cmd == i2cms_pkg::OP_READ) begin
			if (seq_phase == 4'd2) begin
				seq_shift = {seq_shift[6:0], (seq_cmd == i2cms_pkg::OP_READ) ? pin : 1'b0};
				seq_bit = seq_bit + 4'd1;
				if (seq_bit >= i2cms_pkg::BITS_PER_BYTE) begin
					end_command();
					fin = 1'b1;
				end else begin
					seq_phase = 4'd1;
					drive_phase_lines();
				end
			end else begin
				seq_phase = 4'd2;
				drive_phase_lines();
			end
		end else if (seq_phase >= phase_total(seq_cmd)) begin
			if (seq_cmd == i2cms_pkg::OP_RACK)
				seq_ack = pin;
			end_command();
			fin = 1'b1;
		end else begin
			seq_phase = seq_phase + 4'd1;
			drive_phase_lines();
		end
		return fin;
	endfunction

	function automatic void step_sequencer(input logic cv, input logic [2:0] op,
			input logic [7:0] wd, input logic pin);
		logic [15:0] hold;
		logic        fin;
		bus_tick_t   r;
		hold = (cfg_phase_ticks == 16'd0) ? 16'd1 : cfg_phase_ticks;
		fin = 1'b0;
		if (seq_phase == 4'd0) begin
			if (cv && op <= i2cms_pkg::OPCODE_MAX) begin
				seq_cmd = i2cms_pkg::opcode_t'(op);
				seq_phase = 4'd1;
				seq_count = 16'd0;
				seq_bit = 4'd0;
				seq_shift = (op == i2cms_pkg::OP_WRITE) ? wd : 8'h00;
				drive_phase_lines();
			end
		end else begin
			seq_count = seq_count + 16'd1;
			if (seq_count >= hold) begin
				seq_count = 16'd0;
				fin = next_phase(pin);
			end
		end
		r.scl = seq_scl;
		r.sda = seq_sda;
		r.drv = seq_drv;
		r.busy = (seq_phase != 4'd0);
		r.done = fin;
		r.rd = seq_rd;
		r.ack = seq_ack;
		expected_ticks.push_back(r);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic check_tick;
		bus_tick_t want;
		if (expected_ticks.size() == 0) begin
			$display("%0t: result word with nothing expected", $time);
			errors++;
		end else begin
			want = expected_ticks.pop_front();
			check_field("scl_level", 8'(want.scl), 8'(scl_level));
			check_field("sda_level", 8'(want.sda), 8'(sda_level));
			check_field("sda_drive", 8'(want.drv), 8'(sda_drive));
			check_field("busy_res", 8'(want.busy), 8'(busy_res));
			check_field("done_res", 8'(want.done), 8'(done_res));
			check_field("read_data", want.rd, read_data);
			check_field("ack_bit", 8'(want.ack), 8'(ack_bit));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_tick();
		if (hold_request > 0) begin
			recv_wait = hold_request;
			hold_request <= 0;
		end
		if (recv_wait > 0) begin
			recv_wait--;
			out_ready <= 1'b0;
		end else begin
			recv_wait = pick_gap(recv_gap_pct);
			out_ready <= (recv_wait == 0);
		end
	end

	task automatic send_tick(input logic cv, input logic [2:0] op, input logic [7:0] wd,
			input logic pin);
		int gap;
		gap = pick_gap(send_gap_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd_valid <= cv;
		opcode <= op;
		write_data <= wd;
		sda_pin <= pin;
		do @(posedge clk); while (!in_ready);
		step_sequencer(cv, op, wd, pin);
		ticks_sent++;
	endtask

	task automatic idle_ticks(input int count);
		repeat (count)
			send_tick(1'b0, 3'($urandom_range(7)), 8'($urandom_range(255)),
				1'($urandom_range(1)));
	endtask

	// offer the command, then tick until the sequence ends; noisy adds ignored commands
	task automatic run_command(input logic [2:0] op, input logic [7:0] wd, input int pin_mode,
			input bit noisy);
		send_tick(1'b1, op, wd, line_sample(pin_mode));
		while (seq_phase != 4'd0) begin
			send_tick(noisy && $urandom_range(4) == 0, 3'($urandom_range(7)),
				8'($urandom_range(255)), line_sample(pin_mode));
		end
	endtask

	task automatic flush_results;
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_phase_ticks(input logic [15:0] value);
		flush_results();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_phase_ticks = value;
	endtask

	task automatic run_transfer;
		int  n_bytes;
		bit  reading;
		n_bytes = $urandom_range(3, 1);
		reading = 1'($urandom_range(1));
		run_command(i2cms_pkg::OP_START, 8'($urandom_range(255)), 2, 1);
		idle_ticks($urandom_range(2));
		run_command(i2cms_pkg::OP_WRITE, 8'($urandom_range(255)), 2, 1);
		run_command(i2cms_pkg::OP_RACK, 8'($urandom_range(255)), 2, 1);
		for (int i = 0; i < n_bytes; i++) begin
			idle_ticks($urandom_range(2));
			if (reading) begin
				run_command(i2cms_pkg::OP_READ, 8'($urandom_range(255)), 2, 1);
				run_command((i == n_bytes - 1) ? i2cms_pkg::OP_NACK : i2cms_pkg::OP_ACK,
					8'($urandom_range(255)), 2, 1);
			end else begin
				run_command(i2cms_pkg::OP_WRITE, 8'($urandom_range(255)), 2, 1);
				run_command(i2cms_pkg::OP_RACK, 8'($urandom_range(255)), 2, 1);
			end
		end
		if ($urandom_range(7) != 0)
			run_command(i2cms_pkg::OP_STOP, 8'($urandom_range(255)), 2, 1);
		idle_ticks($urandom_range(3));
	endtask

	task automatic run_loose_commands;
		repeat ($urandom_range(4, 1)) begin
			run_command(3'($urandom_range(7)), 8'($urandom_range(255)), 2, 1);
			idle_ticks($urandom_range(2));
		end
	endtask

	task automatic test_reset_state;
		idle_ticks(2);
		send_tick(1'b0, i2cms_pkg::OP_START, 8'hFF, 1'b0);
		flush_results();
	endtask

	task automatic test_each_command;
		run_command(OP_UNUSED, 8'hFF, 1, 0);
		run_command(i2cms_pkg::OP_START, 8'h00, 1, 0);
		run_command(i2cms_pkg::OP_WRITE, 8'hFF, 0, 1);
		run_command(i2cms_pkg::OP_WRITE, 8'h00, 1, 0);
		run_command(i2cms_pkg::OP_WRITE, 8'hA5, 2, 1);
		run_command(i2cms_pkg::OP_RACK, 8'h00, 0, 0);
		run_command(i2cms_pkg::OP_RACK, 8'h00, 1, 0);
		run_command(i2cms_pkg::OP_READ, 8'hFF, 1, 0);
		run_command(i2cms_pkg::OP_READ, 8'h00, 0, 1);
		run_command(i2cms_pkg::OP_READ, 8'h5A, 2, 0);
		run_command(i2cms_pkg::OP_ACK, 8'h00, 2, 0);
		run_command(i2cms_pkg::OP_NACK, 8'h00, 2, 1);
		run_command(i2cms_pkg::OP_STOP, 8'h00, 2, 0);
		flush_results();
	endtask

	task automatic test_bus_transfers;
		int unsigned stop_at;
		int          n;
		stop_at = ticks_sent + 1200;
		n = 0;
		while (ticks_sent < stop_at) begin
			if (n % 6 == 0)
				set_phase_ticks((n % 12 == 0) ? 16'd1 : 16'($urandom_range(6, 0)));
			send_gap_pct = (n % 7 == 3) ? 0 : 15;
			recv_gap_pct = (n % 5 == 2) ? 0 : 15;
			if ($urandom_range(9) < 8)
				run_transfer();
			else
				run_loose_commands();
			if (n % 5 == 4)
				flush_results();
			n++;
		end
		send_gap_pct = 15;
		recv_gap_pct = 15;
		flush_results();
	endtask

	task automatic test_output_stall;
		send_gap_pct = 0;
		hold_request <= 400;
		run_transfer();
		send_gap_pct = 15;
		flush_results();
	endtask

	task automatic test_longest_phase;
		set_phase_ticks(16'd100);
		send_gap_pct = 0;
		recv_gap_pct = 0;
		run_command(i2cms_pkg::OP_STOP, 8'h00, 2, 1);
		send_gap_pct = 15;
		recv_gap_pct = 15;
		set_phase_ticks(16'd1);
		run_command(i2cms_pkg::OP_START, 8'h00, 2, 1);
		flush_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		cmd_valid <= 1'b0;
		opcode <= i2cms_pkg::OP_START;
		write_data <= 8'h00;
		sda_pin <= 1'b1;
		cfg_we <= 1'b0;
		cfg_data <= 16'd1;
		out_ready <= 1'b0;
		cfg_phase_ticks = 16'd1;
		seq_phase = 4'd0;
		seq_count = 16'd0;
		seq_bit = 4'd0;
		seq_shift = 8'h00;
		seq_cmd = i2cms_pkg::OP_START;
		seq_scl = 1'b1;
		seq_sda = 1'b1;
		seq_drv = 1'b1;
		seq_ack = 1'b0;
		seq_rd = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_each_command();
		test_bus_transfers();
		test_output_stall();
		test_longest_phase();

		flush_results();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
sv/i2cms_pkg.sv
sv/i2cms_step.sv
sv/i2cms_top_placeholder.sv
sv/i2c_master_bit_sequencer.sv
bench/testbench.sv
